[design/abpa_pkg.sv]
// Package with shared constants, types and helper functions for the aligned page allocator.
package abpa_pkg;

  localparam int NUM_PAGES       = 4096;
  localparam int MAX_ALIGN_ORDER = 8;
  localparam int WORD_W          = 32;
  localparam int NUM_WORDS       = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W           = $clog2(WORD_W);
  localparam int IDX_W           = $clog2(NUM_PAGES + 1) + 1;
  localparam int ORDER_W         = $clog2(MAX_ALIGN_ORDER + 1) + 1;

  localparam int BASE_W  = 40;
  localparam int USE_W   = 13;
  localparam int COUNT_W = 13;
  localparam int FRAME_W = 41;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_REFUSED = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Smallest k with 2^k >= count, capped at the maximum order.
  function automatic logic [ORDER_W-1:0] align_order(input logic [COUNT_W-1:0] count);
    logic [ORDER_W-1:0] k;
    logic               done;
    k    = '0;
    done = 1'b0;
    for (int i = 0; i < MAX_ALIGN_ORDER; i++) begin
      if (!done && ((32'd1 << i) < {{(32-COUNT_W){1'b0}}, count})) begin
        k = ORDER_W'(i + 1);
      end else begin
        done = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

[design/aligned_bitmap_page_allocator_top.sv]
// Top level: configuration, request sequencer and map memory of the aligned page allocator.
// Each request passes S_CHECK; an allocation then scans with S_RD and S_TEST per page tested;
// the mark or clear pass uses S_MRD and S_MWR per page; out_valid is registered from S_DONE.
// Throughput: one request at a time; busy rises after acceptance and is low in the strobe cycle.
// After reset a clearing pass writes every map word with busy high.
// The result strobe out_valid lasts one cycle; the receiver cannot stall it.
module aligned_bitmap_page_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [abpa_pkg::COUNT_W-1:0]        in_page_count,
  input  logic                                in_may_block,
  input  logic [abpa_pkg::FRAME_W-1:0]        in_free_page_frame,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [abpa_pkg::FRAME_W-1:0]        out_page_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abpa_pkg::FRAME_W-1:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_TEST  = 8'b0001_0000,
    S_MRD   = 8'b0010_0000,
    S_MWR   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  localparam int IW = abpa_pkg::IDX_W;

  state_t state_r, state_nxt;

  logic [abpa_pkg::BASE_W-1:0]  base_r;
  logic [abpa_pkg::USE_W-1:0]   use_r;
  logic                         mode_r, may_r;
  logic [abpa_pkg::COUNT_W-1:0] count_r;
  logic [abpa_pkg::FRAME_W-1:0] frame_r;
  logic [IW-1:0]                limit_r;
  logic [IW-1:0]                start_r, start_nxt;
  logic [IW-1:0]                pos_r, pos_nxt;
  logic [IW-1:0]                mask_r;
  logic                         set_r;
  logic [1:0]                   status_r, status_nxt;
  logic [abpa_pkg::FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic                         ov_r;
  logic [abpa_pkg::ADDR_W-1:0]  clr_addr_r;

  logic                         wr_en;
  logic [abpa_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [abpa_pkg::WORD_W-1:0]  wr_data, rd_data;

  abpa_map_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [IW-1:0] count_x, end_x, hit_next;
  logic [abpa_pkg::BIT_W-1:0] bitsel;
  logic [abpa_pkg::FRAME_W:0] off_w;
  logic [abpa_pkg::WORD_W-1:0] mod_word;

  assign count_x  = IW'(count_r);
  assign end_x    = start_r + count_x;
  assign bitsel   = pos_r[abpa_pkg::BIT_W-1:0];
  assign hit_next = (pos_r + IW'(1) + mask_r) & ~mask_r;
  assign off_w    = {1'b0, frame_r} - {2'b0, base_r};
  assign rd_addr  = pos_r[abpa_pkg::BIT_W +: abpa_pkg::ADDR_W];

  always_comb begin
    mod_word         = rd_data;
    mod_word[bitsel] = set_r;
  end

  assign wr_en   = (state_r == S_CLEAR) || (state_r == S_MWR);
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : rd_addr;
  assign wr_data = (state_r == S_CLEAR) ? '0 : mod_word;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    res_frame_nxt = res_frame_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == abpa_pkg::ADDR_W'(abpa_pkg::NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt    = abpa_pkg::ST_OK;
        res_frame_nxt = '0;
        start_nxt     = '0;
        pos_nxt       = '0;
        if (mode_r == abpa_pkg::MODE_ALLOC) begin
          if (!may_r) begin
            status_nxt = abpa_pkg::ST_REFUSED;
            state_nxt  = S_DONE;
          end else if (count_r == '0 || count_x > limit_r) begin
            status_nxt = abpa_pkg::ST_NOSPACE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          if (off_w[abpa_pkg::FRAME_W] || off_w > {{(abpa_pkg::FRAME_W+1-IW){1'b0}}, limit_r}
              || count_x > limit_r - off_w[IW-1:0]) begin
            status_nxt = abpa_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            start_nxt = off_w[IW-1:0];
            pos_nxt   = off_w[IW-1:0];
            state_nxt = S_MRD;
          end
        end
      end
      S_RD: begin
        if (end_x > limit_r) begin
          status_nxt = abpa_pkg::ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (rd_data[bitsel]) begin
          start_nxt = hit_next;
          pos_nxt   = hit_next;
          state_nxt = S_RD;
        end else if (pos_r + IW'(1) == end_x) begin
          res_frame_nxt = {1'b0, base_r} + abpa_pkg::FRAME_W'(start_r);
          pos_nxt       = start_r;
          state_nxt     = S_MRD;
        end else begin
          pos_nxt   = pos_r + IW'(1);
          state_nxt = S_RD;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        // Write back before the next read so consecutive bits of one word chain correctly.
        if (pos_r + IW'(1) == end_x) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_r + IW'(1);
          state_nxt = S_MRD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      base_r     <= '0;
      use_r      <= abpa_pkg::USE_W'(4096);
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_DONE);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + abpa_pkg::ADDR_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == abpa_pkg::CFG_BASE) begin
          base_r <= cfg_data[abpa_pkg::BASE_W-1:0];
        end else begin
          use_r <= cfg_data[abpa_pkg::USE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    pos_r       <= pos_nxt;
    status_r    <= status_nxt;
    res_frame_r <= res_frame_nxt;
    if (state_r == S_IDLE && start) begin
      mode_r  <= in_mode;
      may_r   <= in_may_block;
      count_r <= in_page_count;
      frame_r <= in_free_page_frame;
      set_r   <= (in_mode == abpa_pkg::MODE_ALLOC);
      mask_r  <= (IW'(1) << abpa_pkg::align_order(in_page_count)) - IW'(1);
      limit_r <= (use_r > abpa_pkg::USE_W'(abpa_pkg::NUM_PAGES)) ?
                 IW'(abpa_pkg::NUM_PAGES) : IW'(use_r);
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = status_r;
  assign out_page_frame = res_frame_r;

endmodule

[design/abpa_map_ram.sv]
// Used-bit map memory: one word of page bits per address, synchronous read.
module abpa_map_ram (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [abpa_pkg::ADDR_W-1:0]            wr_addr,
  input  logic [abpa_pkg::WORD_W-1:0]            wr_data,
  input  logic [abpa_pkg::ADDR_W-1:0]            rd_addr,
  output logic [abpa_pkg::WORD_W-1:0]            rd_data
);

  logic [abpa_pkg::WORD_W-1:0] mem [abpa_pkg::NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
